// File: hdl/stpq_pkg.sv
// ----------------------------------------------------------------------------
// stpq_pkg: shared types and constants for the sorted thread priority queue
// The queue geometry, the operation and status codes, and the types that
// pass between the top level and the cells of the shift chain.
// ----------------------------------------------------------------------------
`default_nettype none

package stpq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int ID_WIDTH       = 8;
  localparam int PRIORITY_WIDTH = 8;
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [ID_WIDTH-1:0]       id;
    logic [PRIORITY_WIDTH-1:0] prio;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic                      enq_en;
    logic                      rem_en;
    logic [ID_WIDTH-1:0]       id;
    logic [PRIORITY_WIDTH-1:0] prio;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/stpq_cell.sv
// ----------------------------------------------------------------------------
// stpq_cell: one slot of the sorted shift chain
// Holds one entry, compares it against the broadcast command and picks its
// next value from itself, the new entry, or a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module stpq_cell
  import stpq_pkg::*;
(
  input  wire                 clk,
  input  wire cell_cmd_t      cmd,
  input  wire                 occ,        // this slot holds a live entry
  input  wire                 is_tail,    // this slot is the current tail
  input  wire entry_t         left_entry,
  input  wire                 left_gt,
  input  wire entry_t         right_entry,
  input  wire                 found_in,   // a match exists nearer the head
  input  wire  [ID_WIDTH-1:0] tail_in,
  output entry_t              entry,
  output logic                gt,
  output logic                found_out,
  output logic [ID_WIDTH-1:0] tail_out
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;

  assign entry     = entry_r;
  assign gt        = occ && (entry_r.prio > cmd.prio);
  assign match     = occ && (entry_r.id == cmd.id);
  assign found_out = found_in | match;
  assign tail_out  = tail_in | (is_tail ? entry_r.id : '0);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.enq_en) begin
      // Slots ahead of the insert point keep their entry, the insert point
      // takes the new one, and the rest shift one place toward the tail.
      if (!gt) begin
        if (left_gt) begin
          entry_nxt.id   = cmd.id;
          entry_nxt.prio = cmd.prio;
        end else begin
          entry_nxt = left_entry;
        end
      end
    end else if (cmd.rem_en && found_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/sorted_thread_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_thread_priority_queue_unit: sorted thread queue with remove
// A chain of cells keeps thread entries ordered from greatest priority at the
// head to smallest at the tail; supports enqueue, dequeue-tail and remove.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                              | tuser
//  --------+-----+------------------------------------+---------------------------
//  in_     | in  | [7:0] thread_id, [15:8] priority_req | [1:0] op
//  out_    | out | [7:0] out_thread_id                | [1:0] status, [2] out_valid
//
// Every accepted beat is fully processed in the cycle it is accepted: all
// cells compare against the broadcast command in parallel and the chain
// shifts at once, so one beat per cycle is sustained unless the output stalls.
// The result appears in the output register in the cycle after acceptance. The
// remove search ripples a found flag down the sixteen cells: the longest path.
// rst_n (synchronous, active low) empties the queue and drops the output beat;
// cell contents are not cleared. A stalled output holds its beat and blocks
// new input only while the held beat is not being taken.
//
`default_nettype none

module sorted_thread_priority_queue_unit
  import stpq_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] thread_id, [15:8] priority_req
  input  wire  [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_thread_id
  output logic [2:0]  out_tuser   // [1:0] status, [2] out_valid
);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_tvalid_r;
  logic [1:0]          status_r, status_nxt;
  logic [ID_WIDTH-1:0] out_id_r, out_id_nxt;
  logic                out_flag_r, out_flag_nxt;

  logic       in_acc;
  logic [1:0] op;
  logic       full;
  logic       empty;
  cell_cmd_t  cmd;

  entry_t              cell_entry [QUEUE_DEPTH];
  logic                cell_gt    [QUEUE_DEPTH];
  logic                cell_found [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] cell_tail  [QUEUE_DEPTH];
  logic                found_any;
  logic [ID_WIDTH-1:0] tail_id;

  // The output register frees up when its beat is taken.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  assign cmd.enq_en = in_acc && (op == OP_ENQ) && !full;
  assign cmd.rem_en = in_acc && (op == OP_REM);
  assign cmd.id     = in_tdata[ID_WIDTH-1:0];
  assign cmd.prio   = in_tdata[8 +: PRIORITY_WIDTH];

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t              left_e, right_e;
      logic                left_g, found_i;
      logic [ID_WIDTH-1:0] tail_i;

      if (i == 0) begin : g_head
        // Nothing sits ahead of the head, so it is the insert point whenever
        // its own entry does not outrank the new one.
        assign left_e  = '0;
        assign left_g  = 1'b1;
        assign found_i = 1'b0;
        assign tail_i  = '0;
      end else begin : g_mid
        assign left_e  = cell_entry[i-1];
        assign left_g  = cell_gt[i-1];
        assign found_i = cell_found[i-1];
        assign tail_i  = cell_tail[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = cell_entry[i+1];
      end

      stpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (CNT_W'(i) < count_r),
        .is_tail     (CNT_W'(i + 1) == count_r),
        .left_entry  (left_e),
        .left_gt     (left_g),
        .right_entry (right_e),
        .found_in    (found_i),
        .tail_in     (tail_i),
        .entry       (cell_entry[i]),
        .gt          (cell_gt[i]),
        .found_out   (cell_found[i]),
        .tail_out    (cell_tail[i])
      );
    end
  endgenerate

  assign found_any = cell_found[QUEUE_DEPTH-1];
  assign tail_id   = cell_tail[QUEUE_DEPTH-1];

  always_comb begin
    count_nxt    = count_r;
    status_nxt   = status_r;
    out_id_nxt   = out_id_r;
    out_flag_nxt = out_flag_r;
    if (in_acc) begin
      status_nxt   = ST_MISS;
      out_id_nxt   = '0;
      out_flag_nxt = 1'b0;
      case (op)
        OP_ENQ: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_OK;
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_DEQ: begin
          if (!empty) begin
            status_nxt   = ST_OK;
            out_id_nxt   = tail_id;
            out_flag_nxt = 1'b1;
            count_nxt    = count_r - 1'b1;
          end
        end
        OP_REM: begin
          if (found_any) begin
            status_nxt = ST_OK;
            count_nxt  = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_id_r   <= out_id_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = {out_flag_r, status_r};

`ifndef SYNTHESIS
  // The entry count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // A successful enqueue grows the queue by exactly one entry.
  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_en |=> count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not grow the queue");

  // A returned entry always carries success status.
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == ST_OK)
    else $error("returned entry without success status");

  // A dequeue from an empty queue leaves the count at zero.
  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_DEQ) && empty |=> count_r == '0)
    else $error("dequeue from empty queue changed the count");
`endif

endmodule

`default_nettype wire
